>>> hw/rtl/ray_triangle_intersect_defines.svh
// ----------------------------------------------------------------------------
// Ray/triangle intersection - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, codes, sequencer types and the product program of the intersector.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_W  = 32;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int OPA_W    = EDGE_W + 1;
  localparam int CHUNK_W  = 17;
  localparam int NCHUNK   = 4;
  localparam int OPB_W    = CHUNK_W * NCHUNK;
  localparam int PROD_W   = OPA_W + CHUNK_W + 1;
  localparam int VEC_W    = 2 * EDGE_W;
  localparam int ACC_W    = 104;
  localparam int QUO_W    = 32;
  localparam int DIV_W    = 136;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int FRAC     = 16;
  localparam int DIST_W   = 31;
  localparam int BARY_W   = 17;
  localparam int NUM_PROD = 24;
  localparam int STEP_W   = 7;
  localparam int MAC_LAST = NUM_PROD * NCHUNK - 1;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_LOAD_AB = 2'd0,
    OP_LOAD_C  = 2'd1,
    OP_TEST    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    REG_MIN_DIST = 1'b0,
    REG_MIN_DET  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    V_DIR, V_E1, V_E2, V_TV, V_P, V_Q
  } vsel_e;

  typedef enum logic [3:0] {
    D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2, D_DET, D_LN, D_MN, D_TN
  } dst_e;

  typedef enum logic [1:0] {
    DV_T, DV_B1, DV_B2
  } dsel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_ABS, ST_CHK_DET, ST_CHK_LN, ST_CHK_MN,
    ST_CHK_TN, ST_DIV_GO, ST_DIV_WAIT, ST_CHK_T, ST_FINISH
  } state_e;

  typedef struct packed {
    vsel_e      a_vec;
    logic [1:0] a_comp;
    vsel_e      b_vec;
    logic [1:0] b_comp;
    logic       neg;
    logic       first;
    logic       last;
    dst_e       dst;
  } uop_t;

  function automatic uop_t uop_mk(vsel_e av, int ac, vsel_e bv, int bc,
                                  logic ng, logic fs, logic ls, dst_e d);
    uop_t u;
    u.a_vec  = av;
    u.a_comp = 2'(ac);
    u.b_vec  = bv;
    u.b_comp = 2'(bc);
    u.neg    = ng;
    u.first  = fs;
    u.last   = ls;
    u.dst    = d;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:    u = uop_mk(V_DIR, 1, V_E2, 2, 1'b0, 1'b1, 1'b0, D_P0);
      5'd1:    u = uop_mk(V_DIR, 2, V_E2, 1, 1'b1, 1'b0, 1'b1, D_P0);
      5'd2:    u = uop_mk(V_DIR, 2, V_E2, 0, 1'b0, 1'b1, 1'b0, D_P1);
      5'd3:    u = uop_mk(V_DIR, 0, V_E2, 2, 1'b1, 1'b0, 1'b1, D_P1);
      5'd4:    u = uop_mk(V_DIR, 0, V_E2, 1, 1'b0, 1'b1, 1'b0, D_P2);
      5'd5:    u = uop_mk(V_DIR, 1, V_E2, 0, 1'b1, 1'b0, 1'b1, D_P2);
      5'd6:    u = uop_mk(V_TV, 1, V_E1, 2, 1'b0, 1'b1, 1'b0, D_Q0);
      5'd7:    u = uop_mk(V_TV, 2, V_E1, 1, 1'b1, 1'b0, 1'b1, D_Q0);
      5'd8:    u = uop_mk(V_TV, 2, V_E1, 0, 1'b0, 1'b1, 1'b0, D_Q1);
      5'd9:    u = uop_mk(V_TV, 0, V_E1, 2, 1'b1, 1'b0, 1'b1, D_Q1);
      5'd10:   u = uop_mk(V_TV, 0, V_E1, 1, 1'b0, 1'b1, 1'b0, D_Q2);
      5'd11:   u = uop_mk(V_TV, 1, V_E1, 0, 1'b1, 1'b0, 1'b1, D_Q2);
      5'd12:   u = uop_mk(V_E1, 0, V_P, 0, 1'b0, 1'b1, 1'b0, D_DET);
      5'd13:   u = uop_mk(V_E1, 1, V_P, 1, 1'b0, 1'b0, 1'b0, D_DET);
      5'd14:   u = uop_mk(V_E1, 2, V_P, 2, 1'b0, 1'b0, 1'b1, D_DET);
      5'd15:   u = uop_mk(V_TV, 0, V_P, 0, 1'b0, 1'b1, 1'b0, D_LN);
      5'd16:   u = uop_mk(V_TV, 1, V_P, 1, 1'b0, 1'b0, 1'b0, D_LN);
      5'd17:   u = uop_mk(V_TV, 2, V_P, 2, 1'b0, 1'b0, 1'b1, D_LN);
      5'd18:   u = uop_mk(V_DIR, 0, V_Q, 0, 1'b0, 1'b1, 1'b0, D_MN);
      5'd19:   u = uop_mk(V_DIR, 1, V_Q, 1, 1'b0, 1'b0, 1'b0, D_MN);
      5'd20:   u = uop_mk(V_DIR, 2, V_Q, 2, 1'b0, 1'b0, 1'b1, D_MN);
      5'd21:   u = uop_mk(V_E2, 0, V_Q, 0, 1'b0, 1'b1, 1'b0, D_TN);
      5'd22:   u = uop_mk(V_E2, 1, V_Q, 1, 1'b0, 1'b0, 1'b0, D_TN);
      5'd23:   u = uop_mk(V_E2, 2, V_Q, 2, 1'b0, 1'b0, 1'b1, D_TN);
      default: u = uop_mk(V_DIR, 0, V_E1, 0, 1'b0, 1'b0, 1'b0, D_P0);
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per cycle, nonnegative operands.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rti_pkg::DIV_W-1:0]     num_i,
  input  logic [rti_pkg::ACC_W-1:0]     den_i,
  output logic                          done_o,
  output logic [rti_pkg::QUO_W-1:0]     quot_o
);

  logic [rti_pkg::DIV_W-1:0] rem_q, sub_q;
  logic [rti_pkg::QUO_W-1:0] quo_q;
  logic [rti_pkg::CNT_W-1:0] cnt_q;
  logic                      busy_q, done_q;
  logic [rti_pkg::DIV_W:0]   diff;
  logic                      ge;

  assign diff = {1'b0, rem_q} - {1'b0, sub_q};
  assign ge   = ~diff[rti_pkg::DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rti_pkg::CNT_W'(rti_pkg::QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      sub_q <= rti_pkg::DIV_W'(den_i) << (rti_pkg::QUO_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff[rti_pkg::DIV_W-1:0];
      end
      quo_q <= {quo_q[rti_pkg::QUO_W-2:0], ge};
      sub_q <= sub_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hw/rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test in signed Q16.16 with exact quotients.
// ----------------------------------------------------------------------------
// Usage: load a triangle with an opcode 0 beat (vertex A, vertex B) and an
// opcode 1 beat (vertex C); each load is taken as one beat and gives no result.
// An opcode 2 beat (origin, direction, max_distance) gives one result beat:
// hit, hit_distance and the barycentrics b1, b2 (zero on a miss).
// A result shows on out_valid_o after its test beat has run through the
// products on the shared 34x18 multiply-accumulate unit (24 products, 4
// chunks each), a drain, the sign fix, four range checks, three divisions
// on the bit-serial divider with a distance check after the first, and the
// output register load. A new beat is taken in the same cycle that the
// result shows; a reject on det or a later check skips to the load.
// in_stall_o is high while a test runs. A finished result sits in the output
// register; the next beat is taken while it waits, and a later result waits
// for it to drain while out_stall_i is high.
// Reset clears the triangle to zero, min_distance to 66, min_determinant to 1.
// Registers sit on an APB port: min_distance at 0x0, min_determinant at 0x4.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_defines.svh"

module ray_triangle_intersect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  first_x_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  first_y_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  first_z_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  second_x_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  second_y_i,
  input  logic signed [rti_pkg::COORD_W-1:0]  second_z_i,
  input  logic [rti_pkg::DIST_W-1:0]          max_distance_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [rti_pkg::DIST_W-1:0]          hit_distance_o,
  output logic [rti_pkg::BARY_W-1:0]          bary_b1_o,
  output logic [rti_pkg::BARY_W-1:0]          bary_b2_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rti_pkg::ADDR_W-1:0]          paddr,
  input  logic [rti_pkg::DATA_W-1:0]          pwdata,
  output logic [rti_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  rti_pkg::state_e state_q, state_d;

  logic signed [rti_pkg::COORD_W-1:0] f_in [3];
  logic signed [rti_pkg::COORD_W-1:0] s_in [3];
  logic signed [rti_pkg::COORD_W-1:0] vertex_a_q [3];
  logic signed [rti_pkg::COORD_W-1:0] dir_q [3];
  logic signed [rti_pkg::EDGE_W-1:0]  e1_q [3];
  logic signed [rti_pkg::EDGE_W-1:0]  e2_q [3];
  logic signed [rti_pkg::EDGE_W-1:0]  tv_q [3];
  logic signed [rti_pkg::VEC_W-1:0]   p_q [3];
  logic signed [rti_pkg::VEC_W-1:0]   q_q [3];
  logic signed [rti_pkg::ACC_W-1:0]   acc_q, acc_d, det_q, ln_q, mn_q, tn_q;
  logic [rti_pkg::DIST_W-1:0]         maxd_q, min_dist_q, min_det_q;
  logic [rti_pkg::STEP_W-1:0]         mac_step_q;

  rti_pkg::uop_t                      uop;
  logic [1:0]                         chunk;
  logic signed [rti_pkg::OPA_W-1:0]   a_op;
  logic signed [rti_pkg::OPB_W-1:0]   b_op;
  logic signed [rti_pkg::CHUNK_W:0]   b_chunk;
  logic signed [rti_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic                               ex_valid_q, ex_neg_q, ex_first_q, ex_last_q;
  logic [1:0]                         ex_chunk_q;
  rti_pkg::dst_e                      ex_dst_q;
  logic signed [rti_pkg::ACC_W-1:0]   prod_ext, term, base;
  logic                               neg_eff;

  rti_pkg::dsel_e                     dsel_q, dsel_d;
  logic                               div_start, div_done;
  logic [rti_pkg::DIV_W-1:0]          div_num;
  logic [rti_pkg::QUO_W-1:0]          div_quot, td_q, b1_q, b2_q;

  logic                               in_acc, cfg_wr, miss, mac_issue, out_load, hit_d;
  logic [rti_pkg::ACC_W-1:0]          det_u, ln_u, mn_u, limit, mn_ln;

  logic                               res_hit_q;
  logic                               out_valid_q, out_hit_q;
  logic [rti_pkg::DIST_W-1:0]         out_dist_q;
  logic [rti_pkg::BARY_W-1:0]         out_b1_q, out_b2_q;

  assign f_in[0] = first_x_i;
  assign f_in[1] = first_y_i;
  assign f_in[2] = first_z_i;
  assign s_in[0] = second_x_i;
  assign s_in[1] = second_y_i;
  assign s_in[2] = second_z_i;

  assign in_stall_o = (state_q != rti_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (rti_pkg::reg_e'(paddr[2]))
      rti_pkg::REG_MIN_DIST: prdata = rti_pkg::DATA_W'(min_dist_q);
      rti_pkg::REG_MIN_DET:  prdata = rti_pkg::DATA_W'(min_det_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= rti_pkg::DIST_W'(66);
      min_det_q  <= rti_pkg::DIST_W'(1);
    end else if (cfg_wr) begin
      unique case (rti_pkg::reg_e'(paddr[2]))
        rti_pkg::REG_MIN_DIST: min_dist_q <= pwdata[rti_pkg::DIST_W-1:0];
        rti_pkg::REG_MIN_DET:  min_det_q  <= pwdata[rti_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // triangle state and ray capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vertex_a_q[i] <= '0;
        e1_q[i]       <= '0;
        e2_q[i]       <= '0;
      end
    end else if (in_acc) begin
      case (rti_pkg::opcode_e'(opcode_i))
        rti_pkg::OP_LOAD_AB: begin
          for (int i = 0; i < 3; i++) begin
            vertex_a_q[i] <= f_in[i];
            e1_q[i] <= rti_pkg::EDGE_W'(s_in[i]) - rti_pkg::EDGE_W'(f_in[i]);
          end
        end
        rti_pkg::OP_LOAD_C: begin
          for (int i = 0; i < 3; i++) begin
            e2_q[i] <= rti_pkg::EDGE_W'(f_in[i]) - rti_pkg::EDGE_W'(vertex_a_q[i]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == rti_pkg::OP_TEST) begin
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= s_in[i];
        tv_q[i]  <= rti_pkg::EDGE_W'(f_in[i]) - rti_pkg::EDGE_W'(vertex_a_q[i]);
      end
      maxd_q <= max_distance_i;
    end
  end

  // multiply-accumulate unit: operand select and chunked product
  assign uop   = rti_pkg::uop_rom(mac_step_q[rti_pkg::STEP_W-1:2]);
  assign chunk = mac_step_q[1:0];

  always_comb begin
    case (uop.a_vec)
      rti_pkg::V_DIR: a_op = rti_pkg::OPA_W'(dir_q[uop.a_comp]);
      rti_pkg::V_E1:  a_op = rti_pkg::OPA_W'(e1_q[uop.a_comp]);
      rti_pkg::V_E2:  a_op = rti_pkg::OPA_W'(e2_q[uop.a_comp]);
      rti_pkg::V_TV:  a_op = rti_pkg::OPA_W'(tv_q[uop.a_comp]);
      default:        a_op = '0;
    endcase
    case (uop.b_vec)
      rti_pkg::V_E1: b_op = rti_pkg::OPB_W'(e1_q[uop.b_comp]);
      rti_pkg::V_E2: b_op = rti_pkg::OPB_W'(e2_q[uop.b_comp]);
      rti_pkg::V_P:  b_op = rti_pkg::OPB_W'(p_q[uop.b_comp]);
      rti_pkg::V_Q:  b_op = rti_pkg::OPB_W'(q_q[uop.b_comp]);
      default:       b_op = '0;
    endcase
    case (chunk)
      2'd0:    b_chunk = {1'b0, b_op[16:0]};
      2'd1:    b_chunk = {1'b0, b_op[33:17]};
      2'd2:    b_chunk = {1'b0, b_op[50:34]};
      default: b_chunk = {b_op[67], b_op[67:51]};
    endcase
    prod_d = rti_pkg::PROD_W'(a_op) * rti_pkg::PROD_W'(b_chunk);
  end

  always_comb begin
    prod_ext = rti_pkg::ACC_W'(prod_q);
    case (ex_chunk_q)
      2'd0:    term = prod_ext;
      2'd1:    term = prod_ext <<< 17;
      2'd2:    term = prod_ext <<< 34;
      default: term = prod_ext <<< 51;
    endcase
    // once det is known negative, accumulate ln, mn and tn with flipped sign
    neg_eff = ex_neg_q ^ (det_q[rti_pkg::ACC_W-1] &&
              (ex_dst_q == rti_pkg::D_LN || ex_dst_q == rti_pkg::D_MN ||
               ex_dst_q == rti_pkg::D_TN));
    base  = ex_first_q ? '0 : acc_q;
    acc_d = base + (term ^ {rti_pkg::ACC_W{neg_eff}}) + rti_pkg::ACC_W'(neg_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      mac_step_q <= '0;
    end else begin
      ex_valid_q <= mac_issue;
      if (in_acc) begin
        mac_step_q <= '0;
      end else if (mac_issue) begin
        mac_step_q <= mac_step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    ex_chunk_q <= chunk;
    ex_neg_q   <= uop.neg;
    ex_first_q <= uop.first && chunk == 2'd0;
    ex_last_q  <= uop.last && chunk == 2'd3;
    ex_dst_q   <= uop.dst;
    if (ex_valid_q) begin
      acc_q <= acc_d;
      if (ex_last_q) begin
        unique case (ex_dst_q)
          rti_pkg::D_P0:  p_q[0] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_P1:  p_q[1] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_P2:  p_q[2] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_Q0:  q_q[0] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_Q1:  q_q[1] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_Q2:  q_q[2] <= acc_d[rti_pkg::VEC_W-1:0];
          rti_pkg::D_DET: det_q  <= acc_d;
          rti_pkg::D_LN:  ln_q   <= acc_d;
          rti_pkg::D_MN:  mn_q   <= acc_d;
          rti_pkg::D_TN:  tn_q   <= acc_d;
          default: ;
        endcase
      end
    end else if (state_q == rti_pkg::ST_ABS && det_q[rti_pkg::ACC_W-1]) begin
      det_q <= -det_q;
    end
  end

  // range checks
  assign det_u = det_q;
  assign ln_u  = ln_q;
  assign mn_u  = mn_q;
  assign mn_ln = mn_u + ln_u;
  assign limit = rti_pkg::ACC_W'({min_det_q, 32'b0});

  // divider
  always_comb begin
    case (dsel_q)
      rti_pkg::DV_T:  div_num = rti_pkg::DIV_W'({tn_q, 16'b0});
      rti_pkg::DV_B1: div_num = rti_pkg::DIV_W'({ln_q, 16'b0});
      default:        div_num = rti_pkg::DIV_W'({mn_q, 16'b0});
    endcase
  end

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (det_u),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (dsel_q)
        rti_pkg::DV_T:  td_q <= div_quot;
        rti_pkg::DV_B1: b1_q <= div_quot;
        default:        b2_q <= div_quot;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    dsel_d    = dsel_q;
    mac_issue = 1'b0;
    div_start = 1'b0;
    miss      = 1'b0;
    out_load  = 1'b0;
    hit_d     = 1'b0;
    unique case (state_q)
      rti_pkg::ST_IDLE: begin
        if (in_acc && opcode_i == rti_pkg::OP_TEST) begin
          state_d = rti_pkg::ST_MAC;
        end
      end
      rti_pkg::ST_MAC: begin
        mac_issue = 1'b1;
        if (mac_step_q == rti_pkg::STEP_W'(rti_pkg::MAC_LAST)) begin
          state_d = rti_pkg::ST_DRAIN;
        end
      end
      rti_pkg::ST_DRAIN: state_d = rti_pkg::ST_ABS;
      rti_pkg::ST_ABS:   state_d = rti_pkg::ST_CHK_DET;
      rti_pkg::ST_CHK_DET: begin
        miss    = (det_u == '0) || (det_u < limit);
        state_d = miss ? rti_pkg::ST_FINISH : rti_pkg::ST_CHK_LN;
      end
      rti_pkg::ST_CHK_LN: begin
        miss    = ln_q[rti_pkg::ACC_W-1] || (det_u < ln_u);
        state_d = miss ? rti_pkg::ST_FINISH : rti_pkg::ST_CHK_MN;
      end
      rti_pkg::ST_CHK_MN: begin
        miss    = mn_q[rti_pkg::ACC_W-1] || (det_u < mn_ln);
        state_d = miss ? rti_pkg::ST_FINISH : rti_pkg::ST_CHK_TN;
      end
      rti_pkg::ST_CHK_TN: begin
        miss    = tn_q[rti_pkg::ACC_W-1];
        dsel_d  = rti_pkg::DV_T;
        state_d = miss ? rti_pkg::ST_FINISH : rti_pkg::ST_DIV_GO;
      end
      rti_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = rti_pkg::ST_DIV_WAIT;
      end
      rti_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (dsel_q == rti_pkg::DV_T) begin
            state_d = rti_pkg::ST_CHK_T;
          end else if (dsel_q == rti_pkg::DV_B1) begin
            dsel_d  = rti_pkg::DV_B2;
            state_d = rti_pkg::ST_DIV_GO;
          end else begin
            hit_d   = 1'b1;
            state_d = rti_pkg::ST_FINISH;
          end
        end
      end
      rti_pkg::ST_CHK_T: begin
        miss    = (td_q >= rti_pkg::QUO_W'(maxd_q)) || (td_q < rti_pkg::QUO_W'(min_dist_q));
        dsel_d  = rti_pkg::DV_B1;
        state_d = miss ? rti_pkg::ST_FINISH : rti_pkg::ST_DIV_GO;
      end
      rti_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rti_pkg::ST_IDLE;
        end
      end
      default: state_d = rti_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rti_pkg::ST_IDLE;
      dsel_q      <= rti_pkg::DV_T;
      out_valid_q <= 1'b0;
      res_hit_q   <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dsel_q  <= dsel_d;
      if (miss) begin
        res_hit_q <= 1'b0;
      end else if (hit_d) begin
        res_hit_q <= 1'b1;
      end
      if (out_load) begin
        out_hit_q <= res_hit_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dist_q <= res_hit_q ? td_q[rti_pkg::DIST_W-1:0] : '0;
      out_b1_q   <= res_hit_q ? b1_q[rti_pkg::BARY_W-1:0] : '0;
      out_b2_q   <= res_hit_q ? b2_q[rti_pkg::BARY_W-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign hit_distance_o = out_dist_q;
  assign bary_b1_o      = out_b1_q;
  assign bary_b2_o      = out_b2_q;

  `RTI_ASSERT_NXT(a_test_starts, in_acc && opcode_i == rti_pkg::OP_TEST,
    state_q == rti_pkg::ST_MAC, "test beat did not start the product sequence")
  `RTI_ASSERT_IMP(a_div_den_pos, state_q == rti_pkg::ST_DIV_WAIT,
    det_q != '0 && !det_q[rti_pkg::ACC_W-1], "division with non-positive determinant")
  `RTI_ASSERT_IMP(a_miss_zero, out_valid_o && !hit_o,
    hit_distance_o == '0 && bary_b1_o == '0 && bary_b2_o == '0, "miss with nonzero payload")
  `RTI_ASSERT_IMP(a_hit_min, out_valid_o && hit_o,
    hit_distance_o >= min_dist_q, "hit closer than min_distance")

endmodule
